/* design/assert_macros.svh */
// assertion macros for the design files, included by fedm_queue
// no dependencies; included where concurrent checks are written
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check that is off while reset is held
`define FEDM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// check that also holds during reset
`define FEDM_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

/* design/fedm_pkg.sv */
// shared types and constants of the forward difference edge map
// no dependencies
package fedm_pkg;

    localparam int EDGE_W      = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    // configuration register indexes
    localparam cfg_idx_t CFG_IMAGE_WIDTH  = 2'd0;
    localparam cfg_idx_t CFG_IMAGE_HEIGHT = 2'd1;
    localparam cfg_idx_t CFG_MAX_GREY     = 2'd2;

    localparam logic [12:0] IMAGE_WIDTH_RST  = 13'd640;
    localparam logic [15:0] IMAGE_HEIGHT_RST = 16'd480;
    localparam logic [15:0] MAX_GREY_RST     = 16'd255;

    // one classified input: up to two results
    typedef struct packed {
        logic [EDGE_W-1:0] edge_value;
        logic              has_edge;
        logic              has_tail;
        logic              tail_end;
    } job_t;

    typedef enum logic {
        PH_EDGE,
        PH_TAIL
    } back_phase_t;

endpackage

/* design/forward_difference_edge_map_top.sv */
// L1 forward-difference edge map over a raster-order greyscale stream;
// uses the shared package and the front, queue and back parts.
// depends on fedm_pkg, fedm_front, fedm_queue, fedm_back
//
// usage:
//   s_ channel takes one pixel per request in raster order; m_ channel gives
//   one edge value per request, frame_end marks the last result of a frame.
//   cfg_ channel writes image_width (0), image_height (1) or max_grey (2);
//   it is always ready, and writes to width or height restart the frame.
//   results run one row behind the input: row 0 gives nothing unless it is the bottom
//   row too; a bottom-row pixel gives the result above (past row 0), then zero.
// timing:
//   one pixel per clock while the queue has room; on the bottom row the output
//   gives one result per clock when not stalled, so the input there is paced
//   by the output. a result reaches the output register through the line
//   store read register, the edge arithmetic and the queue.
// reset:
//   counters clear, registers go to 640 x 480 with max grey 255; the line
//   store is not cleared, each entry is written in a frame before a read of it is used.
// stall:
//   a four-deep queue sits between the front and the output register; when
//   the receiver stalls the queue fills and s_ready drops, nothing is lost.
module forward_difference_edge_map_top import fedm_pkg::*; #(
    parameter int MAX_WIDTH  = 4096,
    parameter int PIXEL_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // pixel input
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [15:0]           s_pixel,
    // edge output
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [EDGE_W-1:0]     m_edge_value,
    output logic                  m_frame_end,
    // register writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  cfg_idx_t              cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic              q_push, q_pop, q_valid;
    job_t              q_in_job, q_head_job;
    logic [QCNT_W-1:0] q_count;

    // register writes never stall
    assign cfg_ready = 1'b1;

    // front: counters, line store, edge arithmetic
    fedm_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_pixel   (s_pixel),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_count   (q_count),
        .q_push    (q_push),
        .q_job     (q_in_job)
    );

    // decoupling queue, front reserves a slot for its in-flight item
    fedm_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_job   (q_in_job),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_job   (q_head_job),
        .count      (q_count)
    );

    // back: one or two results per item into the output register
    fedm_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (q_valid),
        .q_head       (q_head_job),
        .q_pop        (q_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_edge_value (m_edge_value),
        .m_frame_end  (m_frame_end)
    );

endmodule

/* design/fedm_front.sv */
// front part: configuration, raster counters, line store and edge arithmetic
// depends on fedm_pkg
module fedm_front import fedm_pkg::*; #(
    parameter int MAX_WIDTH  = 4096,
    parameter int PIXEL_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [15:0]           s_pixel,
    input  logic                  cfg_valid,
    input  cfg_idx_t              cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [QCNT_W-1:0]     q_count,
    output logic                  q_push,
    output job_t                  q_job
);

    localparam int ADDR_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int SUM_W  = PIXEL_BITS + 1;

    logic [12:0]           image_width_reg;
    logic [15:0]           image_height_reg;
    logic [15:0]           max_grey_reg;
    logic [ADDR_W-1:0]     col_reg, col_next;
    logic [15:0]           row_reg, row_next;

    logic [PIXEL_BITS-1:0] line_mem [MAX_WIDTH];
    logic [PIXEL_BITS-1:0] above_reg, right_reg, pix_reg;
    logic                  s1_valid_reg;
    logic                  s1_edge_reg, s1_tail_reg, s1_last_col_reg;

    logic                  accept, geom_write;
    logic                  last_col, last_row;
    int                    eff_w;
    logic [15:0]           eff_h;
    logic [ADDR_W-1:0]     right_addr;
    logic [PIXEL_BITS-1:0] pix_in;
    logic [PIXEL_BITS-1:0] d_right, d_down;
    logic [16:0]           sum;

    assign pix_in = s_pixel[PIXEL_BITS-1:0];
    assign accept = s_valid && s_ready;
    assign s_ready = (q_count + QCNT_W'(s1_valid_reg)) < QCNT_W'(QUEUE_DEPTH);
    assign geom_write = cfg_valid &&
                        (cfg_index == CFG_IMAGE_WIDTH || cfg_index == CFG_IMAGE_HEIGHT);

    // effective geometry
    always_comb begin
        if (image_width_reg == 13'd0) begin
            eff_w = 1;
        end else if (int'(image_width_reg) > MAX_WIDTH) begin
            eff_w = MAX_WIDTH;
        end else begin
            eff_w = int'(image_width_reg);
        end
        eff_h = (image_height_reg == 16'd0) ? 16'd1 : image_height_reg;
    end

    assign last_col   = (int'(col_reg) + 1) >= eff_w;
    assign last_row   = ({1'b0, row_reg} + 17'd1) >= {1'b0, eff_h};
    assign right_addr = last_col ? col_reg : col_reg + ADDR_W'(1);

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (geom_write) begin
            col_next = '0;
            row_next = '0;
        end else if (accept) begin
            if (last_col) begin
                col_next = '0;
                row_next = last_row ? 16'd0 : row_reg + 16'd1;
            end else begin
                col_next = col_reg + ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg  <= IMAGE_WIDTH_RST;
            image_height_reg <= IMAGE_HEIGHT_RST;
            max_grey_reg     <= MAX_GREY_RST;
            col_reg          <= '0;
            row_reg          <= '0;
            s1_valid_reg     <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[12:0];
                    CFG_IMAGE_HEIGHT: image_height_reg <= cfg_data;
                    CFG_MAX_GREY:     max_grey_reg     <= cfg_data;
                    default: ;
                endcase
            end
            col_reg      <= col_next;
            row_reg      <= row_next;
            s1_valid_reg <= accept;
        end
    end

    // line store: reads see the previous row, write replaces it
    always_ff @(posedge aclk) begin
        if (accept) begin
            above_reg         <= line_mem[col_reg];
            right_reg         <= line_mem[right_addr];
            line_mem[col_reg] <= pix_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            pix_reg         <= pix_in;
            s1_edge_reg     <= (row_reg != 16'd0);
            s1_tail_reg     <= last_row;
            s1_last_col_reg <= last_col;
        end
    end

    // edge arithmetic on the stage after the line store read
    assign d_right = (right_reg > above_reg) ? right_reg - above_reg : above_reg - right_reg;
    assign d_down  = (pix_reg > above_reg) ? pix_reg - above_reg : above_reg - pix_reg;
    assign sum     = 17'(SUM_W'(d_right) + SUM_W'(d_down));

    always_comb begin
        q_job.has_edge = s1_edge_reg;
        q_job.has_tail = s1_tail_reg;
        q_job.tail_end = s1_last_col_reg;
        if (s1_last_col_reg) begin
            q_job.edge_value = '0;
        end else if (sum > {1'b0, max_grey_reg}) begin
            q_job.edge_value = max_grey_reg;
        end else begin
            q_job.edge_value = sum[15:0];
        end
    end

    assign q_push = s1_valid_reg && (s1_edge_reg || s1_tail_reg);

endmodule

/* design/fedm_queue.sv */
// short queue of classified items between the front and back parts
// depends on fedm_pkg and assert_macros.svh
`include "assert_macros.svh"
module fedm_queue import fedm_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  job_t              push_job,
    input  logic              pop,
    output logic              head_valid,
    output job_t              head_job,
    output logic [QCNT_W-1:0] count
);

    job_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign head_valid = (count_reg != '0);
    assign head_job   = slot_reg[rd_ptr_reg];
    assign count      = count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + QCNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    `FEDM_ASSERT(a_no_overflow, push && !pop |-> count_reg < QCNT_W'(QUEUE_DEPTH), "queue overflow")
    `FEDM_ASSERT(a_no_underflow, pop |-> count_reg != '0, "queue underflow")
    `FEDM_ASSERT(a_count_step, push && !pop |=> count_reg == $past(count_reg) + QCNT_W'(1), "count step")
    `FEDM_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> count_reg == '0 && !head_valid, "not empty after reset")

endmodule

/* design/fedm_back.sv */
// back part: expands queued items into results behind an output register
// depends on fedm_pkg
module fedm_back import fedm_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid,
    input  job_t              q_head,
    output logic              q_pop,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [EDGE_W-1:0] m_edge_value,
    output logic              m_frame_end
);

    back_phase_t       phase_reg, phase_next;
    logic              valid_reg, valid_next;
    logic [EDGE_W-1:0] edge_reg, edge_next;
    logic              fe_reg, fe_next;
    logic              load, take_edge, take_tail;

    assign load      = !valid_reg || m_ready;
    assign take_edge = q_valid && (phase_reg == PH_EDGE) && q_head.has_edge;
    assign take_tail = q_valid && ((phase_reg == PH_TAIL) || !q_head.has_edge);

    always_comb begin
        phase_next = phase_reg;
        if (load && take_edge && q_head.has_tail) begin
            phase_next = PH_TAIL;
        end else if (load && take_tail) begin
            phase_next = PH_EDGE;
        end
    end

    always_comb begin
        q_pop      = load && (take_tail || (take_edge && !q_head.has_tail));
        valid_next = valid_reg;
        edge_next  = edge_reg;
        fe_next    = fe_reg;
        if (load) begin
            valid_next = q_valid;
            edge_next  = take_edge ? q_head.edge_value : '0;
            fe_next    = take_tail && q_head.tail_end;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_EDGE;
            valid_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        edge_reg <= edge_next;
        fe_reg   <= fe_next;
    end

    assign m_valid      = valid_reg;
    assign m_edge_value = edge_reg;
    assign m_frame_end  = fe_reg;

endmodule

/* bench/tb_forward_difference_edge_map_top.sv */
`timescale 1ns / 1ps
// self-checking testbench for forward_difference_edge_map_top
// random frames with a local edge predictor; depends on fedm_pkg and the top level
module tb_forward_difference_edge_map_top;
    import fedm_pkg::*;

    localparam int LINE_MAX     = 4096;     // line store depth of the block
    localparam int SETTLE       = 12;       // pipeline plus four-deep queue, with margin
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int RANDOM_ITEMS = 1200;
    localparam int PRINT_MAX    = 30;

    // index with no register behind it, writes there must change nothing
    localparam cfg_idx_t CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic [EDGE_W-1:0] edge_value;
        logic              frame_end;
    } edge_result_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    logic [15:0]           s_pixel   = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    logic [EDGE_W-1:0]     m_edge_value;
    logic                  m_frame_end;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    cfg_idx_t              cfg_index = CFG_IMAGE_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // pixels waiting to be offered, and edge results the block still owes
    logic [15:0]  pixel_queue[$];
    edge_result_t edge_results_due[$];

    // local copy of the block state: previous row, position, registers
    logic [15:0] prev_row_pixels [LINE_MAX];
    int unsigned col_pos      = 0;
    int unsigned row_pos      = 0;
    logic [12:0] width_reg    = IMAGE_WIDTH_RST;
    logic [15:0] height_reg   = IMAGE_HEIGHT_RST;
    logic [15:0] max_grey_reg = MAX_GREY_RST;

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    logic        hold_m         = 1'b0;
    int unsigned error_count    = 0;
    int unsigned cycle_count    = 0;

    forward_difference_edge_map_top i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_pixel      (s_pixel),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_edge_value (m_edge_value),
        .m_frame_end  (m_frame_end),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // 4 ns clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic int unsigned abs_diff(input int unsigned a, input int unsigned b);
        return (a > b) ? a - b : b - a;
    endfunction

    // effective geometry: zero counts as one, width clamps to the line store
    function automatic int unsigned row_length();
        if (width_reg == 0) return 1;
        if (width_reg > LINE_MAX) return LINE_MAX;
        return width_reg;
    endfunction

    function automatic int unsigned frame_rows();
        return (height_reg == 0) ? 1 : height_reg;
    endfunction

    // one pixel taken: queue the result for the pixel above (rows after the
    // first) and the zero result of this pixel on the bottom row
    function void predict_edges(input logic [15:0] pix);
        int unsigned  c;
        int unsigned  above;
        int unsigned  sum;
        logic         last_row;
        logic         last_col;
        edge_result_t res;
        c        = col_pos;
        last_row = (row_pos + 1 >= frame_rows());
        last_col = (c + 1 >= row_length());
        above    = prev_row_pixels[c];
        if (row_pos >= 1) begin
            sum = 0;
            // right border of the row above gives zero
            if (!last_col) begin
                sum = abs_diff(prev_row_pixels[c+1], above) + abs_diff(pix, above);
                if (sum > max_grey_reg) sum = max_grey_reg;
            end
            res.edge_value = sum[15:0];
            res.frame_end  = 1'b0;
            edge_results_due.push_back(res);
        end
        if (last_row) begin
            // bottom row has nothing below, frame ends on its last column
            res.edge_value = '0;
            res.frame_end  = last_col;
            edge_results_due.push_back(res);
        end
        prev_row_pixels[c] = pix;
        if (last_col) begin
            col_pos = 0;
            row_pos = last_row ? 0 : ((row_pos + 1) & 16'hFFFF);
        end else begin
            col_pos = c + 1;
        end
    endfunction

    // geometry writes restart the frame, max grey leaves the position alone
    function void apply_reg_write(input cfg_idx_t idx, input logic [15:0] data);
        case (idx)
            CFG_IMAGE_WIDTH: begin
                width_reg = data[12:0];
                col_pos   = 0;
                row_pos   = 0;
            end
            CFG_IMAGE_HEIGHT: begin
                height_reg = data;
                col_pos    = 0;
                row_pos    = 0;
            end
            CFG_MAX_GREY: begin
                max_grey_reg = data;
            end
            default: begin
            end
        endcase
    endfunction

    // register write request, only issued while the block is idle
    task automatic write_reg(input cfg_idx_t idx, input logic [15:0] data);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        forever begin
            @(posedge aclk);
            if (cfg_ready) break;
        end
        apply_reg_write(idx, data);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_geometry(input logic [15:0] w, input logic [15:0] h,
                                input logic [15:0] grey);
        write_reg(CFG_IMAGE_WIDTH, w);
        write_reg(CFG_IMAGE_HEIGHT, h);
        write_reg(CFG_MAX_GREY, grey);
    endtask

    // block idle: nothing queued or offered, every owed result seen, then a
    // settling wait for row-0 pixels still in the pipe
    task automatic wait_settled();
        while (pixel_queue.size() != 0 || s_valid || edge_results_due.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // 0 none, 1 sender idles, 2 receiver stalls, 3 both
    task automatic set_idling(input int unsigned mode);
        send_idle_pct  = (mode == 1) ? 73 : (mode == 3) ? 37 : 0;
        recv_stall_pct = (mode == 2) ? 73 : (mode == 3) ? 37 : 0;
    endtask

    // random pixels in one of a few styles: full range, flat areas with
    // small steps, values up to max grey, or hard steps between two levels
    task automatic queue_pixels(input int unsigned count);
        int unsigned style;
        int unsigned base;
        logic [15:0] pix;
        style = $urandom_range(0, 3);
        base  = $urandom_range(0, 65535);
        repeat (count) begin
            case (style)
                0: pix = 16'($urandom_range(0, 65535));
                1: pix = 16'(base + $urandom_range(0, 15));
                2: pix = 16'($urandom_range(0, max_grey_reg));
                default: pix = $urandom_range(0, 1) ? base[15:0] : 16'h0000;
            endcase
            pixel_queue.push_back(pix);
        end
    endtask

    // pixel driver: predicts on each accepted request, holds valid and data
    // while the block stalls, otherwise offers the next pixel or idles
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_edges(s_pixel);
            end
            if (!s_valid || s_ready) begin
                if (pixel_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    s_valid <= 1'b1;
                    s_pixel <= pixel_queue.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: random stalls, plus the long hold-off from the stimulus
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= !hold_m && ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // result monitor: each accepted request against the oldest owed result
    always @(posedge aclk) begin
        edge_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (edge_results_due.size() == 0) begin
                error_count++;
                if (error_count <= PRINT_MAX)
                    $display("%0t: unexpected result edge_value=%0d frame_end=%0b",
                             $time, m_edge_value, m_frame_end);
            end else begin
                want = edge_results_due.pop_front();
                if (m_edge_value !== want.edge_value) begin
                    error_count++;
                    if (error_count <= PRINT_MAX)
                        $display("%0t: edge_value mismatch, expected %0d, actual %0d",
                                 $time, want.edge_value, m_edge_value);
                end
                if (m_frame_end !== want.frame_end) begin
                    error_count++;
                    if (error_count <= PRINT_MAX)
                        $display("%0t: frame_end mismatch, expected %0b, actual %0b",
                                 $time, want.frame_end, m_frame_end);
                end
            end
        end
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("forward_difference_edge_map_top test failed");
            $finish;
        end
    end

    initial begin
        int unsigned random_count;
        int unsigned frame_idx;
        int unsigned roll;
        int unsigned frame_len;
        logic [15:0] w_pick;
        logic [15:0] grey_pick;
        random_count = 0;
        frame_idx    = 0;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // reset registers: 640 wide, max grey 255; one row and two pixels
        // give the first two results of row 0
        queue_pixels(642);
        wait_settled();

        // checkerboard of extremes, sums of 131070 saturate at 65535
        set_geometry(16'd3, 16'd3, 16'hFFFF);
        for (int i = 0; i < 9; i++)
            pixel_queue.push_back((i % 2) ? 16'hFFFF : 16'h0000);
        wait_settled();

        // zero max grey: every edge clamps to zero
        write_reg(CFG_MAX_GREY, 16'h0000);
        queue_pixels(9);
        wait_settled();

        // pixels far above max grey, only the sum saturates
        set_geometry(16'd2, 16'd2, 16'd100);
        pixel_queue.push_back(16'd60000);
        pixel_queue.push_back(16'd60010);
        pixel_queue.push_back(16'd1);
        pixel_queue.push_back(16'd2);
        wait_settled();

        // sum under the limit passes unchanged
        write_reg(CFG_MAX_GREY, 16'd1000);
        pixel_queue.push_back(16'd500);
        pixel_queue.push_back(16'd510);
        pixel_queue.push_back(16'd520);
        pixel_queue.push_back(16'd530);
        wait_settled();

        // zero width and height act as a one-pixel frame
        set_geometry(16'd0, 16'd0, 16'd255);
        queue_pixels(2);
        wait_settled();

        // single-row frame: only the zero results of the pixels themselves
        set_geometry(16'd4, 16'd1, 16'hFFFF);
        queue_pixels(4);
        wait_settled();

        // write to the unused index mid-frame must not restart anything
        set_geometry(16'd3, 16'd2, 16'hFFFF);
        queue_pixels(3);
        wait_settled();
        write_reg(CFG_UNUSED, 16'h0001);
        queue_pixels(3);
        wait_settled();

        // tallest frame, only the first rows are reached
        set_geometry(16'd5, 16'hFFFF, 16'd4000);
        queue_pixels(20);
        wait_settled();

        // long receiver hold-off while pixels keep coming: the internal
        // queue fills and the input stalls
        set_idling(0);
        set_geometry(16'd8, 16'd4, 16'hFFFF);
        @(posedge aclk);
        hold_m <= 1'b1;
        queue_pixels(64);
        repeat (300) @(posedge aclk);
        hold_m <= 1'b0;
        wait_settled();

        // sender pauses mid-frame until every owed result is out
        set_idling(3);
        set_geometry(16'd6, 16'd4, 16'd500);
        queue_pixels(15);
        wait_settled();
        queue_pixels(9);
        wait_settled();

        // random frames: mostly small and complete, some cut short by a
        // restart, some running past the frame end into the next one
        while (random_count < RANDOM_ITEMS) begin
            set_idling(frame_idx % 4);
            wait_settled();
            roll = $urandom_range(0, 99);
            if (roll < 80) begin
                roll = $urandom_range(0, 99);
                if (roll < 70)
                    w_pick = 16'($urandom_range(1, 12));
                else if (roll < 90)
                    w_pick = 16'($urandom_range(13, 80));
                else if (roll < 95)
                    w_pick = 16'd0;
                else
                    w_pick = 16'($urandom_range(81, 300));
                write_reg(CFG_IMAGE_WIDTH, w_pick);
                write_reg(CFG_IMAGE_HEIGHT, 16'($urandom_range(0, 5)));
            end
            roll = $urandom_range(0, 99);
            if (roll < 30)
                grey_pick = 16'hFFFF;
            else if (roll < 60)
                grey_pick = 16'($urandom_range(1, 255));
            else if (roll < 90)
                grey_pick = 16'($urandom_range(0, 65535));
            else
                grey_pick = 16'h0000;
            write_reg(CFG_MAX_GREY, grey_pick);
            if ($urandom_range(0, 9) == 0)
                write_reg(CFG_UNUSED, 16'($urandom_range(0, 65535)));

            frame_len = row_length() * frame_rows();
            roll = $urandom_range(0, 99);
            if (roll < 20)
                frame_len = $urandom_range(1, frame_len);
            else if (roll < 30)
                frame_len = frame_len + $urandom_range(1, row_length());
            queue_pixels(frame_len);
            random_count += frame_len;
            frame_idx++;
        end

        wait_settled();
        repeat (SETTLE) @(posedge aclk);
        if (error_count == 0) begin
            $display("forward_difference_edge_map_top test passed");
        end else begin
            $display("forward_difference_edge_map_top test failed");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+design
design/fedm_pkg.sv
design/fedm_front.sv
design/fedm_queue.sv
design/fedm_back.sv
design/forward_difference_edge_map_top.sv
bench/tb_forward_difference_edge_map_top.sv
